FILE: sv/idll_pkg.sv
`default_nettype none
package idll_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DataWidthDefault = 32;

  localparam logic [2:0] FuncAppend = 3'd0;
  localparam logic [2:0] FuncInsert = 3'd1;
  localparam logic [2:0] FuncDelete = 3'd2;
  localparam logic [2:0] FuncRead   = 3'd3;
  localparam logic [2:0] FuncModify = 3'd4;
  localparam logic [2:0] FuncSearch = 3'd5;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotLive  = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         slot;
    logic signed [31:0] data;
    logic [4:0]         count;
  } rsp_t;
endpackage
`default_nettype wire

FILE: sv/indexed_doubly_linked_list_top.sv
// indexed doubly linked list over a fixed store of DEPTH slots
// requests arrive on req_valid_i/req_ready_o with func, position and value;
// each request gives exactly one response on rsp_valid_o/rsp_ready_i
// with status, slot, data and the element count after the request
// one request is worked on at a time; the link and value memories are
// synchronous with one read port each; append and delete go through RD1,
// EXEC, WR_A and DONE, insert adds WR_B and WR_C after WR_A, read/modify
// go RD1, EXEC, DONE and a rejected request goes from RD1 to DONE; search
// does SRCH_RD, SRCH_CHK per node (up to DEPTH), then SRCH_RD if no match
// the response sits in an output register; the next request is taken
// while it waits, but a new response waits until the old one is taken
// after reset a clearing pass over all DEPTH slots sets the link memories
// (next to i+1, prev to none); no request is taken during it
// out-of-range positions count as not live; values are kept in DATA_WIDTH
// bits and returned sign-extended to the 32-bit data field
`default_nettype none
module indexed_doubly_linked_list_top #(
  parameter int unsigned DEPTH = idll_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = idll_pkg::DataWidthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire idll_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output idll_pkg::rsp_t      rsp_o
);
  import idll_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] None = LW'(DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RD1, ST_EXEC, ST_WR_A, ST_WR_B, ST_WR_C,
    ST_SRCH_RD, ST_SRCH_CHK, ST_DONE
  } state_e;

  logic [DATA_WIDTH-1:0] val_mem [DEPTH];
  logic [LW-1:0]         nxt_mem [DEPTH];
  logic [LW-1:0]         prv_mem [DEPTH];
  logic [DEPTH-1:0]      live_q, live_d;

  state_e                state_q, state_d;
  logic [LW-1:0]         head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [LW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         clr_q, clr_d;
  req_t                  req_q, req_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [LW-1:0]         walk_q, walk_d, steps_q, steps_d;
  logic [LW-1:0]         n_q, n_d, pr_q, pr_d, nx_q, nx_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;
  rsp_t                  res_q, res_d;

  // memory ports
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] val_rd_q;
  logic [LW-1:0]         nxt_rd_q, prv_rd_q;
  logic                  val_we, nxt_we, prv_we;
  logic [AW-1:0]         val_wa, nxt_wa, prv_wa;
  logic [DATA_WIDTH-1:0] val_wd;
  logic [LW-1:0]         nxt_wd, prv_wd;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr];
      nxt_rd_q <= nxt_mem[rd_addr];
      prv_rd_q <= prv_mem[rd_addr];
    end
    if (val_we) val_mem[val_wa] <= val_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
  end

  logic [DATA_WIDTH-1:0] req_val;
  logic                  pos_in_range;
  logic                  pos_live;
  logic [31:0]           rd_data_ext;
  logic [LW-1:0]         slot_or_none;

  assign req_val      = DATA_WIDTH'($unsigned(req_q.value));
  assign pos_in_range = ({28'd0, req_q.position} < 32'(DEPTH));
  assign pos_live     = pos_in_range && live_q[pos_q];
  assign rd_data_ext  = 32'(signed'(val_rd_q));
  assign slot_or_none = (nxt_rd_q < None) ? nxt_rd_q : None;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    req_d       = req_q;
    pos_d       = pos_q;
    walk_d      = walk_q;
    steps_d     = steps_q;
    n_d         = n_q;
    pr_d        = pr_q;
    nx_d        = nx_q;
    live_d      = live_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = pos_q;
    val_we      = 1'b0;
    nxt_we      = 1'b0;
    prv_we      = 1'b0;
    val_wa      = pos_q;
    nxt_wa      = pos_q;
    prv_wa      = pos_q;
    val_wd      = req_val;
    nxt_wd      = None;
    prv_wd      = None;

    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        nxt_we = 1'b1;
        nxt_wa = clr_q;
        nxt_wd = LW'(clr_q) + LW'(1);
        prv_we = 1'b1;
        prv_wa = clr_q;
        prv_wd = None;
        clr_d  = clr_q + AW'(1);
        if (LW'(clr_q) == None - LW'(1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          pos_d   = AW'(req_i.position);
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        // check the request; issue the first read for append, insert, delete, read and modify
        res_d.status = StatusOk;
        res_d.slot   = 5'(None);
        res_d.data   = '0;
        case (req_q.func)
          FuncAppend, FuncInsert: begin
            if (req_q.func == FuncInsert && !pos_live) begin
              res_d.status = StatusNotLive;
              state_d = ST_DONE;
            end else if (free_q >= None) begin
              res_d.status = StatusFull;
              state_d = ST_DONE;
            end else begin
              n_d     = free_q;
              rd_en   = 1'b1;
              rd_addr = AW'(free_q);
              state_d = ST_EXEC;
            end
          end
          FuncDelete, FuncRead, FuncModify: begin
            if (!pos_live) begin
              res_d.status = StatusNotLive;
              state_d = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = pos_q;
              state_d = ST_EXEC;
            end
          end
          FuncSearch: begin
            walk_d  = head_q;
            steps_d = '0;
            state_d = ST_SRCH_RD;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_EXEC: begin
        case (req_q.func)
          FuncAppend: begin
            free_d = nxt_rd_q;
            val_we = 1'b1;
            val_wa = AW'(n_q);
            nxt_we = 1'b1;
            nxt_wa = AW'(n_q);
            nxt_wd = None;
            prv_we = 1'b1;
            prv_wa = AW'(n_q);
            prv_wd = tail_q;
            pr_d   = tail_q;
            state_d = ST_WR_A;
          end
          FuncInsert: begin
            free_d = nxt_rd_q;
            val_we = 1'b1;
            val_wa = AW'(n_q);
            nxt_we = 1'b1;
            nxt_wa = AW'(n_q);
            nxt_wd = LW'(pos_q);
            rd_en   = 1'b1;
            rd_addr = pos_q;
            state_d = ST_WR_A;
          end
          FuncDelete: begin
            pr_d = prv_rd_q;
            nx_d = nxt_rd_q;
            res_d.data = rd_data_ext;
            res_d.slot = 5'(slot_or_none);
            nxt_we = 1'b1;
            nxt_wa = pos_q;
            nxt_wd = free_q;
            prv_we = 1'b1;
            prv_wa = pos_q;
            prv_wd = None;
            free_d = LW'(pos_q);
            live_d[pos_q] = 1'b0;
            if (cnt_q != '0) cnt_d = cnt_q - LW'(1);
            state_d = ST_WR_A;
          end
          default: begin
            res_d.data = rd_data_ext;
            res_d.slot = 5'(slot_or_none);
            if (req_q.func == FuncModify) val_we = 1'b1;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WR_A: begin
        case (req_q.func)
          FuncAppend: begin
            if (pr_q < None) begin
              nxt_we = 1'b1;
              nxt_wa = AW'(pr_q);
              nxt_wd = n_q;
            end else begin
              head_d = n_q;
            end
            tail_d = n_q;
            live_d[AW'(n_q)] = 1'b1;
            cnt_d  = cnt_q + LW'(1);
            res_d.slot = 5'(n_q);
            state_d = ST_DONE;
          end
          FuncInsert: begin
            pr_d   = prv_rd_q;
            prv_we = 1'b1;
            prv_wa = AW'(n_q);
            prv_wd = prv_rd_q;
            state_d = ST_WR_B;
          end
          default: begin
            if (pr_q < None) begin
              nxt_we = 1'b1;
              nxt_wa = AW'(pr_q);
              nxt_wd = nx_q;
            end else begin
              head_d = nx_q;
            end
            if (nx_q < None) begin
              prv_we = 1'b1;
              prv_wa = AW'(nx_q);
              prv_wd = pr_q;
            end else begin
              tail_d = pr_q;
            end
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WR_B: begin
        prv_we = 1'b1;
        prv_wa = pos_q;
        prv_wd = n_q;
        if (pr_q < None) begin
          nxt_we = 1'b1;
          nxt_wa = AW'(pr_q);
          nxt_wd = n_q;
        end else begin
          head_d = n_q;
        end
        state_d = ST_WR_C;
      end
      ST_WR_C: begin
        live_d[AW'(n_q)] = 1'b1;
        cnt_d  = cnt_q + LW'(1);
        res_d.slot = 5'(n_q);
        state_d = ST_DONE;
      end
      ST_SRCH_RD: begin
        if (walk_q < None && steps_q < None) begin
          rd_en   = 1'b1;
          rd_addr = AW'(walk_q);
          state_d = ST_SRCH_CHK;
        end else begin
          res_d.status = StatusNotFound;
          state_d = ST_DONE;
        end
      end
      ST_SRCH_CHK: begin
        if (val_rd_q == req_val) begin
          res_d.slot = 5'(walk_q);
          res_d.data = rd_data_ext;
          state_d = ST_DONE;
        end else begin
          walk_d  = nxt_rd_q;
          steps_d = steps_q + LW'(1);
          state_d = ST_SRCH_RD;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
          rsp_d.count = 5'(cnt_q);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      head_q      <= None;
      tail_q      <= None;
      free_q      <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      live_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    pos_q   <= pos_d;
    walk_q  <= walk_d;
    steps_q <= steps_d;
    n_q     <= n_d;
    pr_q    <= pr_d;
    nx_q    <= nx_d;
    rsp_q   <= rsp_d;
    res_q   <= res_d;
  end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
class list_scoreboard;
  localparam int unsigned Slots = 16;
  localparam logic [4:0] NoSlot = 5'd16;

  logic [31:0] slot_value [Slots];
  logic [4:0]  fwd_link [Slots];
  logic [4:0]  back_link [Slots];
  bit          in_list [Slots];
  logic [4:0]  first_slot, last_slot, free_slot, n_elems;
  idll_pkg::rsp_t pending[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned func_seen [8];
  int unsigned status_seen [4];

  function new();
    for (int i = 0; i < Slots; i++) begin
      slot_value[i] = '0;
      fwd_link[i] = 5'(i + 1);
      back_link[i] = NoSlot;
      in_list[i] = 1'b0;
    end
    first_slot = NoSlot;
    last_slot = NoSlot;
    free_slot = '0;
    n_elems = '0;
    errors = 0;
    checked = 0;
  endfunction

  function bit is_live(logic [3:0] s);
    return in_list[s];
  endfunction

  function void note_request(idll_pkg::req_t r);
    idll_pkg::rsp_t e;
    logic [4:0] n, pr, nx, j;
    int steps;
    e.status = idll_pkg::StatusOk;
    e.slot = NoSlot;
    e.data = '0;
    func_seen[r.func]++;
    case (r.func)
      idll_pkg::FuncAppend, idll_pkg::FuncInsert: begin
        if (r.func == idll_pkg::FuncInsert && !is_live(r.position)) begin
          e.status = idll_pkg::StatusNotLive;
        end else if (free_slot >= NoSlot) begin
          e.status = idll_pkg::StatusFull;
        end else begin
          n = free_slot;
          free_slot = fwd_link[n];
          slot_value[n] = r.value;
          in_list[n] = 1'b1;
          if (r.func == idll_pkg::FuncAppend) begin
            fwd_link[n] = NoSlot;
            back_link[n] = last_slot;
            if (last_slot < NoSlot) fwd_link[last_slot] = n;
            else first_slot = n;
            last_slot = n;
          end else begin
            pr = back_link[r.position];
            back_link[n] = pr;
            fwd_link[n] = {1'b0, r.position};
            back_link[r.position] = n;
            if (pr < NoSlot) fwd_link[pr] = n;
            else first_slot = n;
          end
          n_elems++;
          e.slot = n;
        end
      end
      idll_pkg::FuncDelete, idll_pkg::FuncRead, idll_pkg::FuncModify: begin
        if (!is_live(r.position)) begin
          e.status = idll_pkg::StatusNotLive;
        end else begin
          nx = fwd_link[r.position];
          e.data = slot_value[r.position];
          e.slot = nx;
          if (r.func == idll_pkg::FuncModify) begin
            slot_value[r.position] = r.value;
          end else if (r.func == idll_pkg::FuncDelete) begin
            pr = back_link[r.position];
            if (pr < NoSlot) fwd_link[pr] = nx;
            else first_slot = nx;
            if (nx < NoSlot) back_link[nx] = pr;
            else last_slot = pr;
            in_list[r.position] = 1'b0;
            back_link[r.position] = NoSlot;
            fwd_link[r.position] = free_slot;
            free_slot = {1'b0, r.position};
            if (n_elems > 0) n_elems--;
          end
        end
      end
      idll_pkg::FuncSearch: begin
        e.status = idll_pkg::StatusNotFound;
        j = first_slot;
        steps = 0;
        while (j < NoSlot && steps < Slots) begin
          if (slot_value[j] == r.value) begin
            e.status = idll_pkg::StatusOk;
            e.slot = j;
            e.data = slot_value[j];
            break;
          end
          j = fwd_link[j];
          steps++;
        end
      end
      default: ;
    endcase
    e.count = n_elems;
    pending.push_back(e);
  endfunction

  function void check_response(idll_pkg::rsp_t a);
    idll_pkg::rsp_t e;
    checked++;
    if (pending.size() == 0) begin
      $error("unexpected response %p", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    status_seen[a.status]++;
    if (a.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, a.status);
      errors++;
    end
    if (a.slot !== e.slot) begin
      $error("slot: expected %0d, got %0d", e.slot, a.slot);
      errors++;
    end
    if (a.data !== e.data) begin
      $error("data: expected %0h, got %0h", e.data, a.data);
      errors++;
    end
    if (a.count !== e.count) begin
      $error("count: expected %0d, got %0d", e.count, a.count);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  idll_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  idll_pkg::rsp_t rsp;

  int send_idle_pct = 8;
  int recv_idle_pct = 80;
  bit hold_rsp = 1'b0;
  list_scoreboard board;

  indexed_doubly_linked_list_top dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i(req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o(rsp)
  );

  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && req_valid && req_ready) board.note_request(req);
    if (rst_n && rsp_valid && rsp_ready) board.check_response(rsp);
  end

  always @(negedge clk) begin
    if (hold_rsp) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send(input logic [2:0] f, input logic [3:0] p, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req.func <= f;
    req.position <= p;
    req.value <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [3:0] pick_slot();
    logic [3:0] q[$];
    for (int i = 0; i < 16; i++) if (board.in_list[i]) q.push_back(4'(i));
    if (q.size() == 0 || $urandom_range(9) == 0) return 4'($urandom_range(15));
    return q[$urandom_range(q.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_value();
    logic [3:0] s;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(7));
      3: begin
        s = pick_slot();
        return board.in_list[s] ? board.slot_value[s] : $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic random_requests(input int n);
    logic [2:0] f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3: f = idll_pkg::FuncAppend;
        4, 5, 6: f = idll_pkg::FuncInsert;
        7, 8, 9, 10: f = idll_pkg::FuncDelete;
        11, 12: f = idll_pkg::FuncRead;
        13, 14: f = idll_pkg::FuncModify;
        15, 16, 17: f = idll_pkg::FuncSearch;
        default: f = 3'($urandom_range(6, 7));
      endcase
      send(f, pick_slot(), pick_value());
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send(idll_pkg::FuncInsert, 4'd0, 32'd5);
    send(idll_pkg::FuncRead, 4'd15, '0);
    send(idll_pkg::FuncSearch, '0, 32'd1);
    send(idll_pkg::FuncDelete, 4'd3, '0);
    send(idll_pkg::FuncAppend, '0, 32'h8000_0000);
    send(idll_pkg::FuncAppend, '0, 32'h7fff_ffff);
    send(idll_pkg::FuncInsert, 4'd0, 32'hffff_ffff);
    send(idll_pkg::FuncInsert, 4'd1, 32'd0);
    send(idll_pkg::FuncSearch, '0, 32'h7fff_ffff);
    send(idll_pkg::FuncModify, 4'd1, 32'h5555_aaaa);
    send(idll_pkg::FuncRead, 4'd1, '0);
    send(3'd6, 4'd2, 32'd1);
    send(3'd7, 4'd9, 32'd2);
    for (int i = 0; i < 13; i++) send(idll_pkg::FuncAppend, 4'(i), 32'(i) ^ 32'haaaa_5555);
    send(idll_pkg::FuncAppend, '0, 32'd9);
    send(idll_pkg::FuncInsert, 4'd2, 32'd9);
    send(idll_pkg::FuncDelete, 4'd2, '0);
    send(idll_pkg::FuncDelete, 4'd15, '0);
    send(idll_pkg::FuncDelete, 4'd15, '0);
    drain();

    random_requests(230);
    send_idle_pct = 80;
    recv_idle_pct = 8;
    random_requests(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver stalls long while requests keep coming
    fork
      begin
        hold_rsp = 1'b1;
        repeat (300) @(negedge clk);
        hold_rsp = 1'b0;
      end
      random_requests(20);
    join
    drain();
    random_requests(200);

    drain();
    repeat (50) @(posedge clk);
    $display("run: %0d responses checked; func counts %p", board.checked, board.func_seen);
    $display("status counts ok/full/notlive/notfound %p", board.status_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
